>>> hdl/hsg_pkg.sv
// ----------------------------------------------------------------------------
// hsg_pkg
// Shared types and constants for the hsv to grb pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsg_pkg;

  // input beat: hue in degrees, saturation and value in percent
  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } pix_in_t;

  // output beat: 8-bit channel intensities
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } pix_out_t;

  // hue and percent limits
  localparam logic [8:0] HUE_WRAP   = 9'd360;
  localparam logic [6:0] PCT_MAX    = 7'd100;
  localparam logic [6:0] SECTOR_DEG = 7'd60;

  // hue sector codes
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // factors are scaled so that full scale is 100 percent times 60 degrees
  localparam int FACTOR_W = 13;
  localparam logic [FACTOR_W-1:0] FULL_FACTOR = 13'd6000;

  // v * factor, at most 600000
  localparam int PROD_W = 20;
  // (v * factor * 17) >> 6, at most 159375
  localparam int SCALED_W = 18;

  // floor(z / 625) as (z * RECIP) >> RECIP_SHIFT, exact for 18-bit z
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP = 19'd429497;
  localparam int QPROD_W = SCALED_W + RECIP_W;

  // valid stages in the pipeline, the last is the output register
  localparam int STAGES = 6;

endpackage : hsg_pkg

`default_nettype wire

>>> hdl/hsg_sector.sv
// ----------------------------------------------------------------------------
// hsg_sector
// First stage: wraps the hue, clamps the percents and splits the hue into
// a sector and a remainder in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module hsg_sector
  import hsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       stage_en,
  input  wire pix_in_t    pix,
  output logic [2:0]      sector_r,
  output logic [5:0]      rem_r,
  output logic [6:0]      sat_r,
  output logic [6:0]      val_r
);

  logic [8:0] hue_w;
  logic [2:0] sector_nxt;
  logic [8:0] base;
  logic [8:0] rem_full;
  logic [6:0] sat_nxt;
  logic [6:0] val_nxt;

  // wrap and clamp out-of-range inputs
  always_comb begin
    hue_w   = (pix.hue >= HUE_WRAP) ? pix.hue - HUE_WRAP : pix.hue;
    sat_nxt = (pix.saturation > PCT_MAX) ? PCT_MAX : pix.saturation;
    val_nxt = (pix.brightness > PCT_MAX) ? PCT_MAX : pix.brightness;
  end

  // sector by threshold compares, remainder by subtracting the sector base
  always_comb begin
    if (hue_w < 9'd60) begin
      sector_nxt = SEC_RED_YEL;
      base       = 9'd0;
    end else if (hue_w < 9'd120) begin
      sector_nxt = SEC_YEL_GRN;
      base       = 9'd60;
    end else if (hue_w < 9'd180) begin
      sector_nxt = SEC_GRN_CYN;
      base       = 9'd120;
    end else if (hue_w < 9'd240) begin
      sector_nxt = SEC_CYN_BLU;
      base       = 9'd180;
    end else if (hue_w < 9'd300) begin
      sector_nxt = SEC_BLU_MAG;
      base       = 9'd240;
    end else begin
      sector_nxt = SEC_MAG_RED;
      base       = 9'd300;
    end
    rem_full = hue_w - base;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (stage_en) begin
      sector_r <= sector_nxt;
      rem_r    <= rem_full[5:0];
      sat_r    <= sat_nxt;
      val_r    <= val_nxt;
    end
  end

endmodule : hsg_sector

`default_nettype wire

>>> hdl/hsg_factor.sv
// ----------------------------------------------------------------------------
// hsg_factor
// Second stage: forms the p, q and t weights on a common scale of 6000,
// where 6000 is the weight of the value channel itself.
// ----------------------------------------------------------------------------
`default_nettype none

module hsg_factor
  import hsg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                stage_en,
  input  wire logic [5:0]          rem,
  input  wire logic [6:0]          sat,
  output logic [FACTOR_W-1:0]      fp_r,
  output logic [FACTOR_W-1:0]      fq_r,
  output logic [FACTOR_W-1:0]      ft_r
);

  logic [6:0]          sat_inv;
  logic [5:0]          rem_inv;
  logic [FACTOR_W-1:0] fp_nxt;
  logic [FACTOR_W-1:0] fq_nxt;
  logic [FACTOR_W-1:0] ft_nxt;

  // p = (100 - s) * 60, q = 6000 - r*s, t = 6000 - (60 - r)*s
  always_comb begin
    sat_inv = PCT_MAX - sat;
    rem_inv = 6'(SECTOR_DEG) - rem;
    fp_nxt  = FACTOR_W'(sat_inv) * FACTOR_W'(SECTOR_DEG);
    fq_nxt  = FULL_FACTOR - FACTOR_W'(rem) * FACTOR_W'(sat);
    ft_nxt  = FULL_FACTOR - FACTOR_W'(rem_inv) * FACTOR_W'(sat);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (stage_en) begin
      fp_r <= fp_nxt;
      fq_r <= fq_nxt;
      ft_r <= ft_nxt;
    end
  end

endmodule : hsg_factor

`default_nettype wire

>>> hdl/hsg_scale.sv
// ----------------------------------------------------------------------------
// hsg_scale
// One channel lane over three stages: floor(v * factor * 255 / 600000).
// 255/600000 reduces to 17/40000; the /64 is a shift and the /625 a
// reciprocal multiply that is exact over the 18-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module hsg_scale
  import hsg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [2:0]          stage_en,
  input  wire logic [6:0]          val,
  input  wire logic [FACTOR_W-1:0] factor,
  output logic [7:0]               chan_r
);

  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_nxt;
  logic [PROD_W+4:0]   mul17;
  logic [SCALED_W-1:0] scaled_r;
  logic [SCALED_W-1:0] scaled_nxt;
  logic [QPROD_W-1:0]  qprod;
  logic [7:0]          chan_nxt;

  // value times weight
  assign prod_nxt = PROD_W'(val) * PROD_W'(factor);

  // times 17 by shift and add, then drop six bits
  always_comb begin
    mul17      = ((PROD_W+5)'(prod_r) << 4) + (PROD_W+5)'(prod_r);
    scaled_nxt = mul17[SCALED_W+5:6];
  end

  // divide by 625 through the reciprocal
  always_comb begin
    qprod    = QPROD_W'(scaled_r) * QPROD_W'(RECIP);
    chan_nxt = qprod[RECIP_SHIFT+7:RECIP_SHIFT];
  end

  // lane registers
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      prod_r <= prod_nxt;
    end
    if (stage_en[1]) begin
      scaled_r <= scaled_nxt;
    end
    if (stage_en[2]) begin
      chan_r <= chan_nxt;
    end
  end

endmodule : hsg_scale

`default_nettype wire

>>> hdl/hsv_to_grb_pixel.sv
// ----------------------------------------------------------------------------
// hsv_to_grb_pixel
// Converts hue/saturation/value to 8-bit green, red and blue in a
// six-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   ports                          beat
//  -------   ----------------------------   ------------------------------
//  in        in_valid  in_ready  in_data    hue, saturation, brightness
//  out       out_valid out_ready out_data   green, red, blue
//
//  a beat passes six register stages, the last the output register, and can
//  leave once out_valid rises. one beat is taken every cycle while in_ready is
//  high; the stages hand over through per-stage load enables and each lane
//  registers its product, scaled value and quotient.
//  rst_n clears the valid bits only; data registers are not reset.
//  a stalled output holds its beat; upstream stages keep filling empty slots,
//  so in_ready drops only when all six stages hold a beat.
//
`default_nettype none

module hsv_to_grb_pixel
  import hsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pix_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output pix_out_t      out_data
);

  logic [STAGES-1:0]   vld_r;
  logic [STAGES-1:0]   vld_nxt;
  logic [STAGES-1:0]   en;

  logic [2:0]          sec1_r;
  logic [5:0]          rem1_r;
  logic [6:0]          sat1_r;
  logic [6:0]          val1_r;
  logic [2:0]          sec2_r;
  logic [6:0]          val2_r;
  logic [FACTOR_W-1:0] fp2_r;
  logic [FACTOR_W-1:0] fq2_r;
  logic [FACTOR_W-1:0] ft2_r;
  logic [2:0]          sec3_r;
  logic [2:0]          sec4_r;
  logic [2:0]          sec5_r;
  logic [7:0]          cv5_r;
  logic [7:0]          cp5_r;
  logic [7:0]          cq5_r;
  logic [7:0]          ct5_r;
  pix_out_t            out_r;
  pix_out_t            out_nxt;

  // per-stage load enables: a stage loads when empty or when it drains
  always_comb begin
    en[STAGES-1] = out_ready || !vld_r[STAGES-1];
    for (int i = STAGES-2; i >= 0; i--) begin
      en[i] = en[i+1] || !vld_r[i];
    end
  end

  assign in_ready = en[0];

  // valid bits travel with the data
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: hue split and clamping
  hsg_sector u_sector (
    .clk      (clk),
    .stage_en (en[0]),
    .pix      (in_data),
    .sector_r (sec1_r),
    .rem_r    (rem1_r),
    .sat_r    (sat1_r),
    .val_r    (val1_r)
  );

  // stage 2: channel weights
  hsg_factor u_factor (
    .clk      (clk),
    .stage_en (en[1]),
    .rem      (rem1_r),
    .sat      (sat1_r),
    .fp_r     (fp2_r),
    .fq_r     (fq2_r),
    .ft_r     (ft2_r)
  );

  // sideband carried alongside the lanes
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sec2_r <= sec1_r;
      val2_r <= val1_r;
    end
    if (en[2]) begin
      sec3_r <= sec2_r;
    end
    if (en[3]) begin
      sec4_r <= sec3_r;
    end
    if (en[4]) begin
      sec5_r <= sec4_r;
    end
  end

  // stages 3 to 5: four scaling lanes, zero saturation makes all equal
  hsg_scale u_lane_v (
    .clk      (clk),
    .stage_en (en[4:2]),
    .val      (val2_r),
    .factor   (FULL_FACTOR),
    .chan_r   (cv5_r)
  );

  hsg_scale u_lane_p (
    .clk      (clk),
    .stage_en (en[4:2]),
    .val      (val2_r),
    .factor   (fp2_r),
    .chan_r   (cp5_r)
  );

  hsg_scale u_lane_q (
    .clk      (clk),
    .stage_en (en[4:2]),
    .val      (val2_r),
    .factor   (fq2_r),
    .chan_r   (cq5_r)
  );

  hsg_scale u_lane_t (
    .clk      (clk),
    .stage_en (en[4:2]),
    .val      (val2_r),
    .factor   (ft2_r),
    .chan_r   (ct5_r)
  );

  // stage 6: sector picks the channel order
  always_comb begin
    case (sec5_r)
      SEC_RED_YEL: out_nxt = '{green: ct5_r, red: cv5_r, blue: cp5_r};
      SEC_YEL_GRN: out_nxt = '{green: cv5_r, red: cq5_r, blue: cp5_r};
      SEC_GRN_CYN: out_nxt = '{green: cv5_r, red: cp5_r, blue: ct5_r};
      SEC_CYN_BLU: out_nxt = '{green: cq5_r, red: cp5_r, blue: cv5_r};
      SEC_BLU_MAG: out_nxt = '{green: cp5_r, red: ct5_r, blue: cv5_r};
      default:     out_nxt = '{green: cp5_r, red: cv5_r, blue: cq5_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_data  = out_r;

  // backpressure reaches the input only with every stage occupied
  a_ready_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("in_ready low with an empty stage");

  // a beat in stage 5 is never dropped when the output register is enabled
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && en[5]) |=> vld_r[5])
    else $error("beat lost between lane and output register");

  // some output channel is at least as bright as the other two
  a_value_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.green >= out_data.red) && (out_data.green >= out_data.blue)) ||
      ((out_data.red >= out_data.green) && (out_data.red >= out_data.blue)) ||
      ((out_data.blue >= out_data.green) && (out_data.blue >= out_data.red)))
    else $error("no channel holds the maximum");

endmodule : hsv_to_grb_pixel

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the hsv to grb pixel converter against a cycle-free integer model of
// the color math. Directed beats cover every hue sector, grey, the percent and
// hue extremes and out-of-range fields. Random beats then run under three
// flow-control mixes, with one long output hold-off that backs up the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import hsg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 545;
  localparam int HOLD_OFF_CYCLES  = 64;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_REPORTS      = 10;
  localparam time RUN_LIMIT       = 2ms;

  // expected-beat store and integer color predictor
  class pixel_scoreboard;
    pix_out_t expected_grb[$];
    int       fault_count;

    function pix_out_t predict_grb(pix_in_t px);
      int unsigned h, s, v, rem;
      int unsigned full_v, low_p, fall_q, rise_t;
      logic [2:0]  sector;
      logic [7:0]  cv, cp, cq, ct;
      pix_out_t    grb;
      h = px.hue;
      s = px.saturation;
      v = px.brightness;
      // wrap hue, clamp percents
      if (h >= HUE_WRAP) h = h - HUE_WRAP;
      if (s > PCT_MAX) s = PCT_MAX;
      if (v > PCT_MAX) v = PCT_MAX;
      full_v = (v * 255) / 100;
      cv     = full_v[7:0];
      // grey when there is no saturation
      if (s == 0) begin
        grb = pix_out_t'({cv, cv, cv});
        return grb;
      end
      sector = 3'(h / SECTOR_DEG);
      rem    = h % SECTOR_DEG;
      low_p  = (v * (100 - s) * 255) / 10000;
      fall_q = (v * (6000 - rem * s) * 255) / 600000;
      rise_t = (v * (6000 - (60 - rem) * s) * 255) / 600000;
      cp = low_p[7:0];
      cq = fall_q[7:0];
      ct = rise_t[7:0];
      // channel order per sector: green, red, blue
      case (sector)
        SEC_RED_YEL: grb = pix_out_t'({ct, cv, cp});
        SEC_YEL_GRN: grb = pix_out_t'({cv, cq, cp});
        SEC_GRN_CYN: grb = pix_out_t'({cv, cp, ct});
        SEC_CYN_BLU: grb = pix_out_t'({cq, cp, cv});
        SEC_BLU_MAG: grb = pix_out_t'({cp, ct, cv});
        default:     grb = pix_out_t'({cp, cv, cq});
      endcase
      return grb;
    endfunction

    function void note_input(pix_in_t px);
      expected_grb.push_back(predict_grb(px));
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (expected_grb.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0t] unexpected beat g=%0d r=%0d b=%0d",
                   $time, got.green, got.red, got.blue);
        return;
      end
      want = expected_grb.pop_front();
      if (got.green !== want.green || got.red !== want.red || got.blue !== want.blue) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0t] mismatch exp g=%0d r=%0d b=%0d got g=%0d r=%0d b=%0d",
                   $time, want.green, want.red, want.blue,
                   got.green, got.red, got.blue);
      end
    endfunction

    function int pending();
      return expected_grb.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  pix_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  pix_out_t out_data;

  pixel_scoreboard grb_board = new();

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;

  hsv_to_grb_pixel i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // beat monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) grb_board.note_input(in_data);
      if (out_valid && out_ready) grb_board.check_result(out_data);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // random beat, mostly legal ranges with some out-of-range fields
  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.hue = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, 359));
    case ($urandom_range(0, 19))
      0, 1:    px.saturation = 7'($urandom_range(0, 127));
      2, 3:    px.saturation = 7'd0;
      4:       px.saturation = PCT_MAX;
      default: px.saturation = 7'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 19))
      0, 1:    px.brightness = 7'($urandom_range(0, 127));
      2:       px.brightness = 7'd0;
      3:       px.brightness = PCT_MAX;
      default: px.brightness = 7'($urandom_range(0, 100));
    endcase
    return px;
  endfunction

  // offer one beat; called and returns at a falling edge
  task automatic send_pixel(pix_in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n_beats);
    repeat (n_beats) send_pixel(rand_pixel());
  endtask

  // corner beats: every sector edge, grey, zero and full scale, wrap, clamp
  pix_in_t corner_beats [22] = '{
    {9'd0,   7'd100, 7'd100}, {9'd59,  7'd100, 7'd100},
    {9'd60,  7'd100, 7'd100}, {9'd119, 7'd50,  7'd100},
    {9'd120, 7'd100, 7'd100}, {9'd179, 7'd77,  7'd33},
    {9'd180, 7'd100, 7'd100}, {9'd239, 7'd1,   7'd99},
    {9'd240, 7'd100, 7'd100}, {9'd299, 7'd100, 7'd1},
    {9'd300, 7'd100, 7'd100}, {9'd359, 7'd100, 7'd100},
    {9'd200, 7'd0,   7'd100}, {9'd45,  7'd0,   7'd37},
    {9'd90,  7'd100, 7'd0},   {9'd0,   7'd0,   7'd0},
    {9'd360, 7'd80,  7'd90},  {9'd511, 7'd100, 7'd100},
    {9'd30,  7'd127, 7'd100}, {9'd210, 7'd60,  7'd127},
    {9'd400, 7'd127, 7'd127}, {9'd1,   7'd1,   7'd1}
  };

  // main sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    hold_off_req  = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 86;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sparse receiver
    foreach (corner_beats[i]) send_pixel(corner_beats[i]);
    send_random(RANDOM_PER_PHASE);

    // sparse sender
    send_idle_pct = 86;
    recv_idle_pct = 25;
    send_random(RANDOM_PER_PHASE);

    // full rate, opening with a long hold-off so the pipe fills
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    send_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    // drain and let stray beats show up
    while (grb_board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (grb_board.fault_count == 0 && grb_board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
